>>> hdl/stack_alu_with_key_store_macros.svh
// ----------------------------------------------------------------------------
// stack alu assertion macros
// shared property forms for the checker of the stack alu
// ----------------------------------------------------------------------------
`ifndef STACK_ALU_WITH_KEY_STORE_MACROS_SVH
`define STACK_ALU_WITH_KEY_STORE_MACROS_SVH

// same-cycle implication, off during reset
`define SAK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SAK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sak_pkg.sv
// ----------------------------------------------------------------------------
// sak_pkg
// types and constants shared by the stack alu modules
// ----------------------------------------------------------------------------
package sak_pkg;

  localparam int VW  = 32;
  localparam int OPW = 4;

  localparam logic [OPW-1:0] OP_PUSH      = 4'd0;
  localparam logic [OPW-1:0] OP_ADD       = 4'd1;
  localparam logic [OPW-1:0] OP_SUB       = 4'd2;
  localparam logic [OPW-1:0] OP_MUL       = 4'd3;
  localparam logic [OPW-1:0] OP_DIV       = 4'd4;
  localparam logic [OPW-1:0] OP_MOD       = 4'd5;
  localparam logic [OPW-1:0] OP_DOUBLE    = 4'd6;
  localparam logic [OPW-1:0] OP_NEGATE    = 4'd7;
  localparam logic [OPW-1:0] OP_SQUARE    = 4'd8;
  localparam logic [OPW-1:0] OP_CLONE     = 4'd9;
  localparam logic [OPW-1:0] OP_STASH_ADD = 4'd10;
  localparam logic [OPW-1:0] OP_STASH_GET = 4'd11;
  localparam logic [OPW-1:0] OP_STASH_DEL = 4'd12;
  localparam logic [OPW-1:0] OP_OUTPUT    = 4'd13;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_NOKEY   = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_BADOP   = 3'd6;
  localparam logic [2:0] ST_UNUSED  = 3'd7;

  typedef struct packed {
    logic [OPW-1:0]       opcode;
    logic signed [31:0]   push_value;
  } sak_in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic signed [31:0]   top_value;
    logic [8:0]           stack_depth;
  } sak_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic mul_ld;
    logic div_start;
    logic div_ld;
    logic commit;
  } sak_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_mul;
    logic go_div;
    logic div_done;
    logic slot_free;
  } sak_sts_t;

endpackage

>>> hdl/sak_div.sv
// ----------------------------------------------------------------------------
// sak_div
// iterative restoring divider, one quotient bit per cycle, truncating signed
// ----------------------------------------------------------------------------
module sak_div import sak_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          is_mod,
  input  logic [VW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] result
);

  localparam int CNTW = $clog2(VW + 1);

  logic [VW:0]     rem_r, rem_nxt;
  logic [VW-1:0]   quo_r, quo_nxt;
  logic [VW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, done_r, mod_r, neg_q_r, neg_r_r;
  logic [VW:0]     rem_sh, diff;

  always_comb begin
    rem_sh  = {rem_r[VW-1:0], quo_r[VW-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    if (!diff[VW]) begin
      rem_nxt = diff;
      quo_nxt = {quo_r[VW-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_r[VW-2:0], 1'b0};
    end
    cnt_nxt = cnt_r - CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // done pulses for one cycle after the last iteration
      done_r <= busy_r && !start && (cnt_r == CNTW'(1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r   <= dividend[VW-1] ? (-dividend) : dividend;
      dvs_r   <= divisor[VW-1] ? (-divisor) : divisor;
      rem_r   <= '0;
      cnt_r   <= CNTW'(VW);
      mod_r   <= is_mod;
      neg_q_r <= dividend[VW-1] ^ divisor[VW-1];
      neg_r_r <= dividend[VW-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign done = done_r;

  always_comb begin
    if (mod_r) begin
      result = neg_r_r ? (-rem_r[VW-1:0]) : rem_r[VW-1:0];
    end else begin
      result = neg_q_r ? (-quo_r) : quo_r;
    end
  end

endmodule

>>> hdl/sak_dp.sv
// ----------------------------------------------------------------------------
// sak_dp
// datapath: top register, operand memory, stash, alu, divider, output register
// ----------------------------------------------------------------------------
module sak_dp import sak_pkg::*; #(
  parameter int STACK_DEPTH   = 256,
  parameter int STASH_ENTRIES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  sak_cmd_t cmd,
  output sak_sts_t sts,
  input  sak_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sak_out_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = (STASH_ENTRIES > 1) ? $clog2(STASH_ENTRIES) : 1;

  // values below the top live in memory, the top in a register
  logic [VW-1:0] mem [STACK_DEPTH];
  logic [VW-1:0] nos_q;
  logic [VW-1:0] top_r;
  logic [CW-1:0] count_r;
  logic [OPW-1:0] op_r;
  logic [VW-1:0] pv_r;

  logic [VW-1:0]            keys_r [STASH_ENTRIES];
  logic [VW-1:0]            vals_r [STASH_ENTRIES];
  logic [STASH_ENTRIES-1:0] valid_r;
  logic [STASH_ENTRIES-1:0] match_r;

  logic [2:0]    res_status_r, res_status_nxt;
  logic [VW-1:0] res_top_r, res_top_nxt;
  logic [CW-1:0] res_count_r, res_count_nxt;
  logic          mem_we_r, mem_we_nxt;
  logic          st_we_r, st_we_nxt, st_del_r, st_del_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [1:0]    need;
  logic          hit, any_free;
  logic [SW-1:0] hit_idx, free_idx;
  logic [VW-1:0] mul_a, prod, div_res;
  logic          div_done;
  logic          go_mul, go_div;
  logic          out_valid_r;
  sak_out_t      out_data_r;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.opcode;
      pv_r  <= VW'(in_data.push_value);
      nos_q <= mem[cnt_m2[AW-1:0]];
      for (int i = 0; i < STASH_ENTRIES; i++) begin
        match_r[i] <= valid_r[i] && (keys_r[i] == top_r);
      end
    end
  end

  always_comb begin
    hit      = |match_r;
    any_free = ~&valid_r;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = STASH_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = SW'(i);
      if (!valid_r[i]) free_idx = SW'(i);
    end
  end

  always_comb begin
    if (op_r == OP_PUSH || op_r > OP_OUTPUT) begin
      need = 2'd0;
    end else if (op_r <= OP_MOD || op_r == OP_STASH_ADD) begin
      need = 2'd2;
    end else begin
      need = 2'd1;
    end
  end

  always_comb begin
    res_status_nxt = ST_OK;
    res_top_nxt    = top_r;
    res_count_nxt  = count_r;
    mem_we_nxt     = 1'b0;
    st_we_nxt      = 1'b0;
    st_del_nxt     = 1'b0;
    slot_nxt       = hit ? hit_idx : free_idx;
    go_mul         = 1'b0;
    go_div         = 1'b0;
    priority if (op_r > OP_OUTPUT) begin
      res_status_nxt = ST_BADOP;
    end else if (count_r < CW'(need)) begin
      res_status_nxt = ST_UNDER;
    end else begin
      unique case (op_r)
        OP_PUSH, OP_CLONE: begin
          if (count_r >= CW'(STACK_DEPTH)) begin
            res_status_nxt = ST_OVER;
          end else begin
            mem_we_nxt    = (count_r != '0);
            res_top_nxt   = (op_r == OP_PUSH) ? pv_r : top_r;
            res_count_nxt = count_r + CW'(1);
          end
        end
        OP_ADD: begin
          res_top_nxt   = nos_q + top_r;
          res_count_nxt = cnt_m1;
        end
        OP_SUB: begin
          res_top_nxt   = nos_q - top_r;
          res_count_nxt = cnt_m1;
        end
        OP_MUL: begin
          go_mul        = 1'b1;
          res_count_nxt = cnt_m1;
        end
        OP_DIV, OP_MOD: begin
          if (top_r == '0) begin
            res_status_nxt = ST_DIVZERO;
          end else begin
            go_div        = 1'b1;
            res_count_nxt = cnt_m1;
          end
        end
        OP_DOUBLE: res_top_nxt = {top_r[VW-2:0], 1'b0};
        OP_NEGATE: res_top_nxt = -top_r;
        OP_SQUARE: go_mul = 1'b1;
        OP_STASH_ADD: begin
          if (!hit && !any_free) begin
            res_status_nxt = ST_FULL;
          end else begin
            st_we_nxt     = 1'b1;
            res_top_nxt   = nos_q;
            res_count_nxt = cnt_m1;
          end
        end
        OP_STASH_GET: begin
          if (!hit) res_status_nxt = ST_NOKEY;
          else res_top_nxt = vals_r[hit_idx];
        end
        OP_STASH_DEL: begin
          if (!hit) begin
            res_status_nxt = ST_NOKEY;
          end else begin
            st_del_nxt    = 1'b1;
            res_top_nxt   = nos_q;
            res_count_nxt = cnt_m1;
          end
        end
        default: ;
      endcase
    end
  end

  assign mul_a = (op_r == OP_SQUARE) ? top_r : nos_q;
  assign prod  = mul_a * top_r;

  sak_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .is_mod   (op_r == OP_MOD),
    .dividend (nos_q),
    .divisor  (top_r),
    .done     (div_done),
    .result   (div_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_top_r    <= res_top_nxt;
      res_count_r  <= res_count_nxt;
      mem_we_r     <= mem_we_nxt;
      st_we_r      <= st_we_nxt;
      st_del_r     <= st_del_nxt;
      slot_r       <= slot_nxt;
    end else if (cmd.mul_ld) begin
      res_top_r <= prod;
    end else if (cmd.div_ld) begin
      res_top_r <= div_res;
    end
  end

  // commit: stack, stash and output register move together
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we_r) begin
      mem[cnt_m1[AW-1:0]] <= top_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && st_we_r) begin
      keys_r[slot_r] <= top_r;
      vals_r[slot_r] <= nos_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count_r     <= res_count_r;
        out_valid_r <= 1'b1;
        if (st_we_r) valid_r[slot_r] <= 1'b1;
        if (st_del_r) valid_r[slot_r] <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top_r                  <= res_top_r;
      out_data_r.status      <= res_status_r;
      out_data_r.top_value   <= (res_count_r != '0) ? 32'(res_top_r) : 32'd0;
      out_data_r.stack_depth <= 9'(res_count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.go_mul    = go_mul;
  assign sts.go_div    = go_div;
  assign sts.div_done  = div_done;
  assign sts.slot_free = !out_valid_r || !out_stall;

endmodule

>>> hdl/sak_ctrl.sv
// ----------------------------------------------------------------------------
// sak_ctrl
// sequencer: accept, execute, multiply or divide, commit
// ----------------------------------------------------------------------------
module sak_ctrl import sak_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sak_sts_t sts,
  output sak_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.go_mul) begin
          state_nxt = S_MUL;
        end else if (sts.go_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_ld = 1'b1;
          state_nxt  = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> hdl/stack_alu_with_key_store.sv
// ----------------------------------------------------------------------------
// stack_alu_with_key_store
// stack machine alu with a small key/value stash, one operation per transaction
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one operation (opcode, push_value); a
//   transaction completes when in_valid is high and in_stall low
//   out_valid/out_stall/out_data return exactly one result per operation
//   (status, top_value, stack_depth) in operation order
//   each operation passes through execute and commit steps; mul and square
//   add a multiply step that registers the product, and div and mod with a
//   nonzero divisor a divide step that waits for the one-bit-per-cycle
//   divider; a new operation is taken the cycle after the previous one commits
//   the result sits in an output register, so the next operation is taken
//   while it waits; if the receiver keeps stalling, the following operation
//   holds in its commit step and in_stall stays high
//   reset empties the stack and clears every stash entry; stack memory and
//   stash keys/values are not cleared, nothing reads them before a write
// ----------------------------------------------------------------------------
module stack_alu_with_key_store import sak_pkg::*; #(
  parameter int STACK_DEPTH   = 256,
  parameter int STASH_ENTRIES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sak_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sak_out_t out_data
);

  // command and status between sequencer and datapath
  sak_cmd_t cmd;
  sak_sts_t sts;

  // sequencer: one operation at a time
  sak_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: stack, stash, alu, divider and result register
  sak_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .STASH_ENTRIES (STASH_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hdl/sak_chk.sv
// ----------------------------------------------------------------------------
// sak_chk
// port-level checks of the stack alu, attached by bind
// ----------------------------------------------------------------------------
`include "stack_alu_with_key_store_macros.svh"

module sak_chk import sak_pkg::*; #(
  parameter int STACK_DEPTH = 256
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input sak_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input sak_out_t out_data
);

  `SAK_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `SAK_ASSERT_IMP(a_depth_max, out_valid, out_data.stack_depth <= 9'(STACK_DEPTH), "stack depth beyond capacity")
  `SAK_ASSERT_IMP(a_empty_top, out_valid && out_data.stack_depth == 9'd0, out_data.top_value == 32'sd0, "empty stack with nonzero top")
  `SAK_ASSERT_IMP(a_status_code, out_valid, out_data.status != ST_UNUSED, "undefined status code")

endmodule

bind stack_alu_with_key_store sak_chk #(.STACK_DEPTH(STACK_DEPTH)) u_sak_chk (.*);
